[rtl/core/adpcm_two_tap_predictive_decoder_top_assert.svh]
// Assertion macros for the two-tap ADPCM decoder.
// Every macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef ADPCM_TWO_TAP_PREDICTIVE_DECODER_TOP_ASSERT_SVH
`define ADPCM_TWO_TAP_PREDICTIVE_DECODER_TOP_ASSERT_SVH

// Same-cycle implication.
`define ATPD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ATPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/atpd_pkg.sv]
package atpd_pkg;

	localparam int BLOCK_LEN_DEF = 16;
	localparam int CODE_BITS_DEF = 4;

	localparam int CODE_W     = 4;
	localparam int CODE_MAX_W = 8;
	localparam int BYTE_W     = 8;
	localparam int HDR_W      = 6;
	localparam int SHIFT_W    = 4;
	localparam int TYPE_W     = 2;
	localparam int NUM_TYPES  = 4;
	localparam int COEF_W     = 18;
	localparam int Q_SHIFT    = 16;
	localparam int DATA_W     = 32;
	localparam int SAMPLE_W   = 16;
	localparam int FIFO_DEPTH = 2;

	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_A0  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_B0  = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_REGS = 4'd8;

	localparam logic OP_START  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sd32767;
	localparam logic signed [DATA_W-1:0] SAT_MIN = -32'sd32768;

	// One classified word handed from the front end to the execution back end.
	typedef struct packed {
		logic                is_start;
		logic [SAMPLE_W-1:0] init;
		logic [DATA_W-1:0]   resid;
		logic [TYPE_W-1:0]   ptype;
	} cmd_t;

endpackage

[rtl/core/atpd_front.sv]
module atpd_front #(
	parameter int BLOCK_LEN = atpd_pkg::BLOCK_LEN_DEF,
	parameter int CODE_BITS = atpd_pkg::CODE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          op,
	input  logic [atpd_pkg::BYTE_W-1:0]   initial_byte,
	input  logic [atpd_pkg::HDR_W-1:0]    block_header,
	input  logic [atpd_pkg::CODE_W-1:0]   code,
	input  logic                          full,
	output logic                          push,
	output atpd_pkg::cmd_t                cmd
);

	localparam int CNT_W = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;

	logic [CNT_W-1:0]                    cnt_q;
	logic [atpd_pkg::SHIFT_W-1:0]        shift_q;
	logic [atpd_pkg::TYPE_W-1:0]         type_q;
	logic                                blk_start;
	logic [atpd_pkg::SHIFT_W-1:0]        shift_now;
	logic [atpd_pkg::TYPE_W-1:0]         type_now;
	logic [atpd_pkg::CODE_MAX_W-1:0]     code_ext;
	logic signed [CODE_BITS-1:0]         code_trim;
	logic [atpd_pkg::DATA_W-1:0]         resid_base;

	assign in_stall = full;
	assign push     = in_valid && !full;

	always_comb begin
		blk_start  = (cnt_q == '0);
		shift_now  = blk_start ? block_header[atpd_pkg::SHIFT_W-1:0] : shift_q;
		type_now   = blk_start ? block_header[atpd_pkg::HDR_W-1:atpd_pkg::SHIFT_W] : type_q;
		code_ext   = atpd_pkg::CODE_MAX_W'(code);
		code_trim  = code_ext[CODE_BITS-1:0];
		resid_base = atpd_pkg::DATA_W'(code_trim);

		cmd.is_start = (op == atpd_pkg::OP_START);
		cmd.init     = {initial_byte, {(atpd_pkg::SAMPLE_W - atpd_pkg::BYTE_W){1'b0}}};
		cmd.resid    = resid_base << shift_now;
		cmd.ptype    = type_now;
	end

	// Block countdown and the latched header live here, ahead of the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			shift_q <= '0;
			type_q  <= '0;
		end else if (push) begin
			if (op == atpd_pkg::OP_START) begin
				cnt_q <= '0;
			end else begin
				shift_q <= shift_now;
				type_q  <= type_now;
				cnt_q   <= blk_start ? CNT_W'(BLOCK_LEN - 1) : cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/atpd_fifo.sv]
module atpd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  atpd_pkg::cmd_t wdata,
	input  logic           pop,
	output atpd_pkg::cmd_t rdata,
	output logic           full,
	output logic           empty
);

	localparam int PTR_W = (atpd_pkg::FIFO_DEPTH > 1) ? $clog2(atpd_pkg::FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(atpd_pkg::FIFO_DEPTH + 1);

	atpd_pkg::cmd_t   mem_q [atpd_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(atpd_pkg::FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(atpd_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(atpd_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/atpd_back.sv]
module atpd_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [atpd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [atpd_pkg::COEF_W-1:0]       cfg_data,
	input  logic                              empty,
	input  atpd_pkg::cmd_t                    cmd,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [atpd_pkg::SAMPLE_W-1:0] sample_out
);

	localparam int PROD_W = atpd_pkg::DATA_W + atpd_pkg::COEF_W;

	logic [atpd_pkg::COEF_W-1:0]        coef_a_q [atpd_pkg::NUM_TYPES];
	logic [atpd_pkg::COEF_W-1:0]        coef_b_q [atpd_pkg::NUM_TYPES];
	logic signed [atpd_pkg::DATA_W-1:0] pd_q;
	logic signed [atpd_pkg::DATA_W-1:0] ppd_q;
	logic [atpd_pkg::DATA_W-1:0]        run_q;
	logic                               out_valid_q;
	logic signed [atpd_pkg::DATA_W-1:0] raw_q;

	logic signed [atpd_pkg::COEF_W-1:0] ca;
	logic signed [atpd_pkg::COEF_W-1:0] cb;
	logic signed [PROD_W-1:0]           pa;
	logic signed [PROD_W-1:0]           pb;
	logic signed [PROD_W:0]             psum;
	logic [atpd_pkg::DATA_W-1:0]        pred;
	logic [atpd_pkg::DATA_W-1:0]        delta;
	logic [atpd_pkg::DATA_W-1:0]        run_next;

	assign pop       = !empty && (cmd.is_start || !out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	always_comb begin
		ca       = coef_a_q[cmd.ptype];
		cb       = coef_b_q[cmd.ptype];
		pa       = pd_q * ca;
		pb       = ppd_q * cb;
		psum     = (PROD_W + 1)'(pa) + (PROD_W + 1)'(pb);
		pred     = psum[atpd_pkg::Q_SHIFT + atpd_pkg::DATA_W - 1:atpd_pkg::Q_SHIFT];
		delta    = cmd.resid + pred;
		run_next = run_q + delta;
	end

	always_comb begin
		priority if (raw_q < atpd_pkg::SAT_MIN) begin
			sample_out = atpd_pkg::SAMPLE_W'(atpd_pkg::SAT_MIN);
		end else if (raw_q > atpd_pkg::SAT_MAX) begin
			sample_out = atpd_pkg::SAMPLE_W'(atpd_pkg::SAT_MAX);
		end else begin
			sample_out = raw_q[atpd_pkg::SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < atpd_pkg::NUM_TYPES; i++) begin
				coef_a_q[i] <= '0;
				coef_b_q[i] <= '0;
			end
		end else if (cfg_we) begin
			priority if (cfg_index < atpd_pkg::CFG_COEF_B0) begin
				coef_a_q[atpd_pkg::TYPE_W'(cfg_index - atpd_pkg::CFG_COEF_A0)] <= cfg_data;
			end else if (cfg_index < atpd_pkg::CFG_NUM_REGS) begin
				coef_b_q[atpd_pkg::TYPE_W'(cfg_index - atpd_pkg::CFG_COEF_B0)] <= cfg_data;
			end else begin
				// Writes past the register list are dropped.
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pd_q        <= '0;
			ppd_q       <= '0;
			run_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && cmd.is_start) begin
				pd_q  <= '0;
				ppd_q <= '0;
				run_q <= atpd_pkg::DATA_W'($signed(cmd.init));
			end else if (pop) begin
				ppd_q <= pd_q;
				pd_q  <= delta;
				run_q <= run_next;
			end
			if (pop && !cmd.is_start) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !cmd.is_start) begin
			raw_q <= run_next;
		end
	end

endmodule

[rtl/core/adpcm_two_tap_predictive_decoder_top.sv]
// A sample word is written into the queue, then popped into the output register.
// Throughput: one word per cycle while out_stall is low; the back end's recursive two-tap
// multiply-add and accumulate loop has no register inside it.
// Reset: arst_n clears asynchronously the filter taps, running sample, block
// countdown, latched header, coefficients, queue and output valid.
module adpcm_two_tap_predictive_decoder_top #(
	parameter int BLOCK_LEN = atpd_pkg::BLOCK_LEN_DEF,
	parameter int CODE_BITS = atpd_pkg::CODE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [atpd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [atpd_pkg::COEF_W-1:0]          cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 op,
	input  logic [atpd_pkg::BYTE_W-1:0]          initial_byte,
	input  logic [atpd_pkg::HDR_W-1:0]           block_header,
	input  logic [atpd_pkg::CODE_W-1:0]          code,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [atpd_pkg::SAMPLE_W-1:0] sample_out
);

	// The front end classifies each input word: it runs the block countdown,
	// latches the shift and predictor type at block starts, and expands the
	// residual code. It needs none of the filter state, so it can run ahead.
	// The short queue between the two halves lets the input keep flowing
	// while a finished sample waits in the output register.

	atpd_pkg::cmd_t front_cmd;
	atpd_pkg::cmd_t head_cmd;
	logic           push;
	logic           pop;
	logic           full;
	logic           empty;

	atpd_front #(
		.BLOCK_LEN (BLOCK_LEN),
		.CODE_BITS (CODE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.initial_byte (initial_byte),
		.block_header (block_header),
		.code         (code),
		.full         (full),
		.push         (push),
		.cmd          (front_cmd)
	);

	atpd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_cmd),
		.pop    (pop),
		.rdata  (head_cmd),
		.full   (full),
		.empty  (empty)
	);

	// The back end holds the filter taps and running sample. A start word
	// reloads them without producing output; a sample word forms the Q16
	// prediction, updates the taps and registers the new running sample,
	// which is saturated to 16 bits on its way out.
	atpd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.empty      (empty),
		.cmd        (head_cmd),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out)
	);

endmodule

[rtl/core/atpd_checker.sv]
`include "adpcm_two_tap_predictive_decoder_top_assert.svh"

module atpd_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_stall,
	input logic                                 out_valid,
	input logic                                 out_stall,
	input logic signed [atpd_pkg::SAMPLE_W-1:0] sample_out
);

	logic in_acc;
	logic idle_take;

	assign in_acc    = in_valid && !in_stall;
	assign idle_take = !in_acc && !out_stall;

	// A waiting output word holds its value.
	`ATPD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sample_out), "output word changed while stalled")

	// The input side only backs up after the output side has been stalled.
	`ATPD_ASSERT_NOW(a_stall_cause, $rose(in_stall), $past(out_valid && out_stall), "input stalled without output back-pressure")

	// With no new words and a free output, the queue and the output register drain.
	`ATPD_ASSERT_NEXT(a_drain, idle_take ##1 idle_take ##1 idle_take, !out_valid, "pipeline did not drain")

endmodule

bind adpcm_two_tap_predictive_decoder_top atpd_checker u_atpd_checker (.*);
